FILE: rtl/nbgps_pkg.sv
package nbgps_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int DIM_DEF           = 3;
  localparam int FRAC_BITS_DEF     = 16;

  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_STEP  = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  localparam logic [2:0] AT_POS   = 3'd0;
  localparam logic [2:0] AT_SPD   = 3'd1;
  localparam logic [2:0] AT_ACC   = 3'd2;
  localparam logic [2:0] AT_MASS  = 3'd3;
  localparam logic [2:0] AT_DRAG  = 3'd4;
  localparam logic [2:0] AT_FIXED = 3'd5;
  localparam logic [2:0] AT_TIME  = 3'd6;
  localparam logic [2:0] AT_BAD   = 3'd7;

  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_DOWN_GRAV = 3'd1;
  localparam logic [2:0] REG_GRAV_CONST = 3'd2;
  localparam logic [2:0] REG_COUNT     = 3'd3;
  localparam logic [2:0] REG_EPSILON   = 3'd4;

  localparam int PADDR_W = 5;

  typedef struct packed {
    logic [30:0]        time_step;
    logic signed [31:0] down_gravity;
    logic signed [31:0] gravity_const;
    logic [6:0]         particle_count;
    logic [15:0]        epsilon;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic        sqrt;
    logic [63:0] opa;
    logic [31:0] opb;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } unit_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_CMD, ST_READ, ST_RESULT,
    ST_HDT0, ST_HDT1, ST_HDT2,
    ST_PI, ST_PFX, ST_GMI, ST_PJ,
    ST_DRD, ST_DRD2, ST_DSUB, ST_DACC,
    ST_SQ, ST_SQW, ST_GM, ST_GM2, ST_Q1W, ST_Q2, ST_Q2W,
    ST_U, ST_UW, ST_UACC,
    ST_MRD, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
    ST_TIME
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [32:0] abs33(input logic signed [31:0] x);
    logic signed [32:0] e;
    e = 33'(x);
    return x[31] ? 33'(-e) : 33'(e);
  endfunction

endpackage

FILE: rtl/nbgps_cmd_if.sv
interface nbgps_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [5:0]         particle_index;
  logic [2:0]         attribute;
  logic [1:0]         axis;
  logic signed [31:0] write_value;

  modport source (output valid, func, particle_index, attribute, axis, write_value,
                  input ready);
  modport sink (input valid, func, particle_index, attribute, axis, write_value,
                output ready);
endinterface

FILE: rtl/nbgps_rsp_if.sv
interface nbgps_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               status;

  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

FILE: rtl/nbgps_seq_unit.sv
module nbgps_seq_unit import nbgps_pkg::*; #(
  parameter int DIV_W = 55
) (
  input  logic      clk,
  input  logic      rst,
  input  unit_req_t req,
  output unit_rsp_t rsp
);
  localparam int CW = $clog2((DIV_W > 32 ? DIV_W : 32) + 1);

  logic              busy;
  logic              done;
  logic              sqrt;
  logic [CW-1:0]     cnt;
  logic [63:0]       sh;
  logic [34:0]       rem;
  logic [63:0]       q;
  logic [31:0]       dvs;
  logic [34:0]       r1;
  logic [34:0]       trial;
  logic              fits;
  logic [34:0]       diffv;

  always_comb begin
    if (sqrt) begin
      r1    = {rem[32:0], sh[63:62]};
      trial = {q[32:0], 2'b01};
    end else begin
      r1    = {rem[33:0], sh[63]};
      trial = {3'b000, dvs};
    end
    fits  = (r1 >= trial);
    diffv = r1 - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        sqrt <= req.sqrt;
        dvs  <= req.opb;
        rem  <= '0;
        q    <= '0;
        sh   <= req.sqrt ? req.opa : (req.opa << (64 - DIV_W));
        cnt  <= req.sqrt ? CW'(32) : CW'(DIV_W);
      end else if (busy) begin
        rem <= fits ? diffv : r1;
        q   <= {q[62:0], fits};
        sh  <= sqrt ? (sh << 2) : (sh << 1);
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = q;
endmodule

FILE: rtl/nbgps_core.sv
module nbgps_core import nbgps_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int DIM           = DIM_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic signed [31:0] ct,
  output logic          ct_we,
  output logic signed [31:0] ct_wd,
  nbgps_cmd_if.sink     cmd,
  nbgps_rsp_if.source   rsp
);
  localparam int NW    = $clog2(MAX_PARTICLES + 1);
  localparam int IW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int VD    = MAX_PARTICLES * DIM;
  localparam int VW    = $clog2(VD);
  localparam int KW    = $clog2(DIM + 1);
  localparam int KIW   = $clog2(DIM);
  localparam int DIV_W = 39 + FRAC_BITS;
  localparam logic signed [63:0] HALF   = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] HALF32 = 32'sd1 <<< (FRAC_BITS - 1);
  localparam logic [63:0]        QCLAMP = 64'd1 << 38;

  state_t state, state_next;

  logic signed [31:0] pos_mem  [VD];
  logic signed [31:0] spd_mem  [VD];
  logic signed [31:0] acc_mem  [VD];
  logic signed [31:0] mass_mem [MAX_PARTICLES];
  logic signed [31:0] drag_mem [MAX_PARTICLES];
  logic               fix_mem  [MAX_PARTICLES];
  logic signed [31:0] pos_q, spd_q, acc_q, mass_q, drag_q;
  logic               fix_q;

  logic [VW-1:0] vaddr, vwaddr;
  logic [IW-1:0] saddr;
  logic pos_we, spd_we, acc_we, mass_we, drag_we, fix_we;
  logic signed [31:0] pos_wd, spd_wd;

  logic [1:0]         c_func;
  logic [5:0]         c_idx;
  logic [2:0]         c_attr;
  logic [1:0]         c_axis;
  logic signed [31:0] c_wv;

  logic [NW-1:0] n, i, j;
  logic [KW-1:0] k;
  logic [VW-1:0] base_i, base_j, cmd_e;
  logic          cmd_err, k_last, res_free;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod, qm;

  unit_req_t ureq;
  unit_rsp_t ursp;

  logic signed [31:0] sys [DIM];
  logic signed [31:0] diff [DIM];
  logic signed [31:0] hdt2, gmi, pi_r, mag, v_r, a_r, x_r, t_r;
  logic signed [31:0] res_rv;
  logic               res_st;
  logic [63:0]        d2;
  logic [31:0]        dist_r;
  logic [38:0]        qabs;
  logic               qneg;
  logic signed [63:0] dsp;

  logic signed [31:0] diff_c, gm_c, unit_c, t_c, disp_c, rd_c;
  logic signed [31:0] dk;
  logic signed [63:0] ures_s;
  logic [64:0]        d2_sum;

  nbgps_seq_unit #(.DIV_W(DIV_W)) u_unit (
    .clk(clk), .rst(rst), .req(ureq), .rsp(ursp)
  );

  assign n = (32'(cfg.particle_count) > MAX_PARTICLES) ? NW'(MAX_PARTICLES)
                                                       : NW'(cfg.particle_count);
  assign cmd_e    = VW'(32'(c_idx) * DIM + 32'(c_axis));
  assign k_last   = (k == KW'(DIM - 1));
  assign res_free = !rsp.valid || rsp.ready;
  assign qm       = (prod + HALF) >>> FRAC_BITS;
  assign dk       = diff[k[KIW-1:0]];

  always_comb begin
    cmd_err = 1'b0;
    if (!(c_func == FN_WRITE || c_func == FN_READ) || c_attr == AT_BAD) begin
      cmd_err = 1'b1;
    end else if (c_attr != AT_TIME) begin
      if (32'(c_idx) >= 32'(n)) begin
        cmd_err = 1'b1;
      end
      if (c_attr <= AT_ACC && 32'(c_axis) >= DIM) begin
        cmd_err = 1'b1;
      end
    end
  end

  always_comb begin
    diff_c = sat32(64'(pos_q) - 64'(pi_r));
    gm_c   = sat32(qm);
    ures_s = ursp.res;
    unit_c = dk[31] ? 32'(-ures_s) : ures_s[31:0];
    t_c    = sat32(64'(a_r) - qm + 64'(sys[k[KIW-1:0]]));
    disp_c = sat32(dsp + qm);
    d2_sum = {1'b0, d2} + {1'b0, prod};
    case (c_attr)
      AT_POS:   rd_c = pos_q;
      AT_SPD:   rd_c = spd_q;
      AT_ACC:   rd_c = acc_q;
      AT_MASS:  rd_c = mass_q;
      AT_DRAG:  rd_c = drag_q;
      AT_FIXED: rd_c = {31'd0, fix_q};
      default:  rd_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) state_next = ST_CMD;
      end
      ST_CMD: begin
        if (c_func == FN_STEP) state_next = ST_HDT0;
        else if (cmd_err || c_func == FN_WRITE || c_attr == AT_TIME) state_next = ST_RESULT;
        else state_next = ST_READ;
      end
      ST_READ:   state_next = ST_RESULT;
      ST_RESULT: begin
        if (res_free) state_next = ST_IDLE;
      end
      ST_HDT0: state_next = ST_HDT1;
      ST_HDT1: state_next = ST_HDT2;
      ST_HDT2: state_next = ST_PI;
      ST_PI: begin
        state_next = (i >= n) ? ST_TIME : ST_PFX;
      end
      ST_PFX: begin
        if (fix_q) state_next = ST_PI;
        else if (abs33(cfg.gravity_const) > 33'(cfg.epsilon)) state_next = ST_GMI;
        else state_next = ST_MRD;
      end
      ST_GMI: state_next = ST_PJ;
      ST_PJ: begin
        if (j >= n) state_next = ST_MRD;
        else if (j != i) state_next = ST_DRD;
      end
      ST_DRD:  state_next = ST_DRD2;
      ST_DRD2: state_next = ST_DSUB;
      ST_DSUB: state_next = ST_DACC;
      ST_DACC: state_next = k_last ? ST_SQ : ST_DRD;
      ST_SQ:   state_next = ST_SQW;
      ST_SQW: begin
        if (ursp.done) state_next = (ursp.res <= 64'(cfg.epsilon)) ? ST_PJ : ST_GM;
      end
      ST_GM:  state_next = ST_GM2;
      ST_GM2: state_next = ST_Q1W;
      ST_Q1W: begin
        if (ursp.done) state_next = ST_Q2;
      end
      ST_Q2:  state_next = ST_Q2W;
      ST_Q2W: begin
        if (ursp.done) state_next = ST_U;
      end
      ST_U:  state_next = ST_UW;
      ST_UW: begin
        if (ursp.done) state_next = ST_UACC;
      end
      ST_UACC: state_next = k_last ? ST_PJ : ST_U;
      ST_MRD:  state_next = ST_M1;
      ST_M1:   state_next = ST_M2;
      ST_M2:   state_next = ST_M3;
      ST_M3:   state_next = ST_M4;
      ST_M4:   state_next = ST_M5;
      ST_M5:   state_next = k_last ? ST_PI : ST_MRD;
      ST_TIME: state_next = ST_RESULT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = (state == ST_IDLE);
    vaddr   = base_i + VW'(k);
    vwaddr  = base_i + VW'(k);
    saddr   = IW'(i);
    pos_we  = 1'b0;
    spd_we  = 1'b0;
    acc_we  = 1'b0;
    mass_we = 1'b0;
    drag_we = 1'b0;
    fix_we  = 1'b0;
    pos_wd  = c_wv;
    spd_wd  = c_wv;
    ct_we   = 1'b0;
    ct_wd   = c_wv;
    mul_a   = '0;
    mul_b   = '0;
    ureq    = '0;
    case (state)
      ST_CMD: begin
        vaddr  = cmd_e;
        vwaddr = cmd_e;
        saddr  = IW'(c_idx);
        if (!cmd_err && c_func == FN_WRITE) begin
          case (c_attr)
            AT_POS:   pos_we  = 1'b1;
            AT_SPD:   spd_we  = 1'b1;
            AT_ACC:   acc_we  = 1'b1;
            AT_MASS:  mass_we = 1'b1;
            AT_DRAG:  drag_we = 1'b1;
            AT_FIXED: fix_we  = 1'b1;
            AT_TIME:  ct_we   = 1'b1;
            default:  ct_we   = 1'b0;
          endcase
        end
      end
      ST_HDT0: begin
        mul_a = {1'b0, cfg.time_step};
        mul_b = {1'b0, cfg.time_step};
      end
      ST_HDT1: begin
        mul_a = sat32(qm);
        mul_b = HALF32;
      end
      ST_PFX: begin
        mul_a = cfg.gravity_const;
        mul_b = mass_q;
      end
      ST_DRD2: vaddr = base_j + VW'(k);
      ST_DSUB: begin
        mul_a = diff_c;
        mul_b = diff_c;
      end
      ST_SQ: begin
        ureq.start = 1'b1;
        ureq.sqrt  = 1'b1;
        ureq.opa   = d2;
      end
      ST_SQW: saddr = IW'(j);
      ST_GM: begin
        mul_a = gmi;
        mul_b = mass_q;
      end
      ST_GM2: begin
        ureq.start = 1'b1;
        ureq.opa   = 64'(abs33(gm_c)) << FRAC_BITS;
        ureq.opb   = dist_r;
      end
      ST_Q2: begin
        ureq.start = 1'b1;
        ureq.opa   = 64'(qabs) << FRAC_BITS;
        ureq.opb   = dist_r;
      end
      ST_U: begin
        ureq.start = 1'b1;
        ureq.opa   = 64'(abs33(dk)) << FRAC_BITS;
        ureq.opb   = dist_r;
      end
      ST_UW: begin
        mul_a = unit_c;
        mul_b = mag;
      end
      ST_M1: begin
        mul_a = drag_q;
        mul_b = spd_q;
      end
      ST_M2: begin
        mul_a = hdt2;
        mul_b = t_c;
      end
      ST_M3: begin
        mul_a = {1'b0, cfg.time_step};
        mul_b = v_r;
      end
      ST_M4: begin
        pos_we = 1'b1;
        pos_wd = sat32(64'(x_r) + 64'(disp_c));
        mul_a  = {1'b0, cfg.time_step};
        mul_b  = t_r;
      end
      ST_M5: begin
        spd_we = 1'b1;
        spd_wd = sat32(64'(v_r) + qm);
      end
      ST_TIME: begin
        ct_we = 1'b1;
        ct_wd = sat32(64'(ct) + 64'(cfg.time_step));
      end
      default: cmd.ready = (state == ST_IDLE);
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    pos_q  <= pos_mem[vaddr];
    spd_q  <= spd_mem[vaddr];
    acc_q  <= acc_mem[vaddr];
    mass_q <= mass_mem[saddr];
    drag_q <= drag_mem[saddr];
    fix_q  <= fix_mem[saddr];
    if (pos_we)  pos_mem[vwaddr]  <= pos_wd;
    if (spd_we)  spd_mem[vwaddr]  <= spd_wd;
    if (acc_we)  acc_mem[vwaddr]  <= c_wv;
    if (mass_we) mass_mem[saddr]  <= c_wv;
    if (drag_we) drag_mem[saddr]  <= c_wv;
    if (fix_we)  fix_mem[saddr]   <= (c_wv != 32'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
      for (int m = 0; m < DIM; m++) sys[m] <= '0;
    end else begin
      if (state == ST_RESULT && res_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            c_func <= cmd.func;
            c_idx  <= cmd.particle_index;
            c_attr <= cmd.attribute;
            c_axis <= cmd.axis;
            c_wv   <= cmd.write_value;
          end
        end
        ST_CMD: begin
          res_st <= cmd_err;
          res_rv <= (!cmd_err && c_func == FN_READ && c_attr == AT_TIME) ? ct : '0;
        end
        ST_READ: res_rv <= rd_c;
        ST_RESULT: begin
          if (res_free) begin
            rsp.read_value <= res_rv;
            rsp.status     <= res_st;
          end
        end
        ST_HDT2: begin
          hdt2   <= sat32(qm);
          i      <= '0;
          base_i <= '0;
        end
        ST_PFX: begin
          k <= '0;
          if (fix_q) begin
            i      <= i + NW'(1);
            base_i <= base_i + VW'(DIM);
          end else begin
            for (int m = 0; m < DIM; m++) begin
              sys[m] <= (m == 1 && abs33(cfg.down_gravity) > 33'(cfg.epsilon))
                        ? sat32(-64'(cfg.down_gravity)) : 32'sd0;
            end
          end
        end
        ST_GMI: begin
          gmi    <= sat32(qm);
          j      <= '0;
          base_j <= '0;
        end
        ST_PJ: begin
          k  <= '0;
          d2 <= '0;
          if (j < n && j == i) begin
            j      <= j + NW'(1);
            base_j <= base_j + VW'(DIM);
          end
        end
        ST_DRD2: pi_r <= pos_q;
        ST_DSUB: diff[k[KIW-1:0]] <= diff_c;
        ST_DACC: begin
          d2 <= d2_sum[64] ? '1 : d2_sum[63:0];
          k  <= k_last ? '0 : k + KW'(1);
        end
        ST_SQW: begin
          if (ursp.done) begin
            dist_r <= ursp.res[31:0];
            if (ursp.res <= 64'(cfg.epsilon)) begin
              j      <= j + NW'(1);
              base_j <= base_j + VW'(DIM);
            end
          end
        end
        ST_GM2: qneg <= gm_c[31];
        ST_Q1W: begin
          if (ursp.done) qabs <= (ursp.res > QCLAMP) ? QCLAMP[38:0] : ursp.res[38:0];
        end
        ST_Q2W: begin
          if (ursp.done) begin
            mag <= qneg ? sat32(-ures_s) : sat32(ures_s);
            k   <= '0;
          end
        end
        ST_UACC: begin
          sys[k[KIW-1:0]] <= sat32(64'(sys[k[KIW-1:0]]) + qm);
          if (k_last) begin
            k      <= '0;
            j      <= j + NW'(1);
            base_j <= base_j + VW'(DIM);
          end else begin
            k <= k + KW'(1);
          end
        end
        ST_M1: begin
          v_r <= spd_q;
          a_r <= acc_q;
          x_r <= pos_q;
        end
        ST_M2: t_r <= t_c;
        ST_M3: dsp <= qm;
        ST_M5: begin
          if (k_last) begin
            k      <= '0;
            i      <= i + NW'(1);
            base_i <= base_i + VW'(DIM);
          end else begin
            k <= k + KW'(1);
          end
        end
        ST_TIME: begin
          res_rv <= '0;
          res_st <= 1'b0;
        end
        default: res_st <= res_st;
      endcase
    end
  end

endmodule

FILE: rtl/nbody_gravity_particle_step.sv
// Channel  Role    Payload                                              Transfer
// cmd      sink    func, particle_index, attribute, axis, write_value   valid && ready
// rsp      source  read_value, status                                   valid && ready
// apb      slave   psel, penable, pwrite, paddr, pwdata, prdata         psel && penable
//
// A write, a time read or an error goes from ST_CMD straight to ST_RESULT; a read passes ST_READ between.
// During a step the shared divide and square root unit retires one quotient bit or one root
// bit a cycle.
// Synchronous active-high reset clears control state; stores are undefined until written.
// The command channel is not ready while an item is in work; a stalled result holds.
module nbody_gravity_particle_step import nbgps_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int DIM           = DIM_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  nbgps_cmd_if.sink          cmd,
  nbgps_rsp_if.source        rsp
);
  localparam logic [30:0] TS_RESET = 31'((64'd1 << FRAC_BITS) / 100);

  cfg_t               cfg;
  logic signed [31:0] ct;
  logic               ct_we;
  logic signed [31:0] ct_wd;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step      <= TS_RESET;
      cfg.down_gravity   <= '0;
      cfg.gravity_const  <= '0;
      cfg.particle_count <= '0;
      cfg.epsilon        <= 16'd1;
      ct                 <= '0;
    end else begin
      if (ct_we) ct <= ct_wd;
      if (wr) begin
        case (paddr[4:2])
          REG_TIME_STEP:  cfg.time_step      <= pwdata[30:0];
          REG_DOWN_GRAV:  cfg.down_gravity   <= pwdata;
          REG_GRAV_CONST: cfg.gravity_const  <= pwdata;
          REG_COUNT:      cfg.particle_count <= pwdata[6:0];
          REG_EPSILON:    cfg.epsilon        <= pwdata[15:0];
          default:        cfg.epsilon        <= cfg.epsilon;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_TIME_STEP:  prdata = {1'b0, cfg.time_step};
      REG_DOWN_GRAV:  prdata = cfg.down_gravity;
      REG_GRAV_CONST: prdata = cfg.gravity_const;
      REG_COUNT:      prdata = {25'd0, cfg.particle_count};
      REG_EPSILON:    prdata = {16'd0, cfg.epsilon};
      default:        prdata = '0;
    endcase
  end

  nbgps_core #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .DIM(DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .ct(ct),
    .ct_we(ct_we),
    .ct_wd(ct_wd),
    .cmd(cmd),
    .rsp(rsp)
  );
endmodule
